@@ rtl/uet_pkg.sv @@
// Shared types, codes and default sizes for the undirected edge table.
// Used by the controller, the datapath and the top level; depends on nothing.
package uet_pkg;

    // Default sizes
    localparam int UET_MAX_EDGES = 64;
    localparam int UET_NODE_BITS = 16;

    // Fixed field widths on the stream ports
    localparam int NODE_FIELD_W = 16;
    localparam int ACT_W        = 2;
    localparam int ST_W         = 3;

    // Operation codes
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE     = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture a new input transaction, restart the scan
        logic scan;        // walk the stored edges
        logic shift_init;  // point the read pipe just past the removed entry
        logic shift;       // move later entries down one place
        logic finish;      // emit the final result and commit the update
    } uet_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_done;   // read pipe drained, nothing more to issue
        logic need_shift;  // remove found its edge
        logic out_free;    // output register can take a result this cycle
    } uet_stat_t;

endpackage

@@ rtl/undirected_edge_table.sv @@
// Top level of the undirected edge table: stream ports, controller and datapath.
// Depends on uet_pkg, uet_ctrl, uet_dp (which holds uet_ram).
//
//  port group | dir | tdata / tuser / tlast contents
//  -----------+-----+----------------------------------------------------------
//  s_*        | in  | tuser: action; tdata: node_a, node_b
//  m_*        | out | tdata: neighbor, adjacent, status; tlast: last result
//
// The scan reads one stored edge per cycle while no held-back list neighbor stalls it;
//   the read pipe then drains, the controller passes to its done state, and the final
//   result is loaded into the output register before the next transaction is taken.
// An add, test or remove stops issuing reads once the matching entry has been read.
// A remove then moves each later entry down one place, none when the match is the last entry.
// A list always scans the whole table; each held-back neighbor waits while m_tready is low.
// Reset clears the fill count and control state only; the edge RAM is not cleared.
// A new transaction is taken as soon as the previous result is in the output register.
module undirected_edge_table
    import uet_pkg::*;
#(
    parameter int MAX_EDGES = UET_MAX_EDGES,
    parameter int NODE_BITS = UET_NODE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] node_a, [31:16] node_b
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] neighbor, [16] adjacent, [19:17] status, zero fill
    output logic        m_tlast
);

    uet_cmd_t cmd;
    uet_stat_t stat;

    logic [NODE_FIELD_W-1:0] neighbor;
    logic                    adjacent;
    logic [ST_W-1:0]         status;

    uet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uet_dp #(
        .MAX_EDGES (MAX_EDGES),
        .NODE_BITS (NODE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (s_tuser),
        .in_node_a    (s_tdata[15:0]),
        .in_node_b    (s_tdata[31:16]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_neighbor (neighbor),
        .out_adjacent (adjacent),
        .out_status   (status),
        .out_last     (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {4'b0000, status, adjacent, neighbor};

endmodule

@@ rtl/uet_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module uet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/uet_ctrl.sv @@
// Sequencer for the edge table: accept, scan, optional shift, final result.
// Depends on uet_pkg for the command and status structs.
module uet_ctrl
    import uet_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  uet_stat_t stat,
    output uet_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.pipe_done)
                begin
                    if (stat.need_shift)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.pipe_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/uet_dp.sv @@
// Datapath for the edge table: edge RAM, read pipe, compare, shift and output register.
// Depends on uet_pkg and uet_ram.
module uet_dp
    import uet_pkg::*;
#(
    parameter int MAX_EDGES = UET_MAX_EDGES,
    parameter int NODE_BITS = UET_NODE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  uet_cmd_t                cmd,
    output uet_stat_t               stat,
    input  logic [ACT_W-1:0]        in_action,
    input  logic [NODE_FIELD_W-1:0] in_node_a,
    input  logic [NODE_FIELD_W-1:0] in_node_b,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [NODE_FIELD_W-1:0] out_neighbor,
    output logic                    out_adjacent,
    output logic [ST_W-1:0]         out_status,
    output logic                    out_last
);

    localparam int IDX_W  = $clog2(MAX_EDGES);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = 2 * NODE_BITS;

    // Captured request
    logic [ACT_W-1:0]     action_reg;
    logic [NODE_BITS-1:0] a_reg;
    logic [NODE_BITS-1:0] b_reg;

    // Table fill and read pipe
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic [CNT_W-1:0]     rd_idx_reg,    rd_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg,   chk_idx_next;
    logic                 found_reg,     found_next;
    logic [IDX_W-1:0]     found_idx_reg, found_idx_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [NODE_BITS-1:0] hold_nb_reg,   hold_nb_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [NODE_FIELD_W-1:0] out_nb_reg,    out_nb_next;
    logic                    out_adj_reg,   out_adj_next;
    logic [ST_W-1:0]         out_st_reg,    out_st_next;
    logic                    out_last_reg,  out_last_next;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [EDGE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [EDGE_W-1:0] ram_rdata;

    // Compare and control terms
    logic [NODE_BITS-1:0] ea;
    logic [NODE_BITS-1:0] eb;
    logic                 is_list;
    logic                 edge_hit;
    logic                 list_hit;
    logic [NODE_BITS-1:0] list_nb;
    logic                 out_free;
    logic                 stall;
    logic                 issue_ok;
    logic                 issue_go;
    logic                 push_mid;
    logic                 full;
    logic                 add_ok;

    uet_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry under test: node a in the low half, node b in the high half
    assign ea       = ram_rdata[NODE_BITS-1:0];
    assign eb       = ram_rdata[EDGE_W-1:NODE_BITS];
    assign is_list  = (action_reg == ACT_LIST);
    assign edge_hit = chk_valid_reg &&
                      (((ea == a_reg) && (eb == b_reg)) || ((ea == b_reg) && (eb == a_reg)));
    assign list_hit = chk_valid_reg && is_list && ((ea == a_reg) || (eb == a_reg));
    assign list_nb  = (ea == a_reg) ? eb : ea;

    // Pipe control; a list hit waits when the previous neighbor cannot leave
    assign out_free = !out_valid_reg || out_ready;
    assign stall    = cmd.scan && list_hit && hold_valid_reg && !out_free;
    assign push_mid = cmd.scan && list_hit && hold_valid_reg && out_free;
    assign issue_ok = (rd_idx_reg < count_reg) && !(cmd.scan && found_reg && !is_list);
    assign issue_go = (cmd.scan || cmd.shift) && issue_ok && !stall;
    assign ram_raddr = stall ? chk_idx_reg : rd_idx_reg[IDX_W-1:0];

    assign full   = (count_reg == CNT_W'(MAX_EDGES));
    assign add_ok = (action_reg == ACT_ADD) && !found_reg && !full;

    assign stat.pipe_done  = !chk_valid_reg && !issue_ok;
    assign stat.need_shift = (action_reg == ACT_REMOVE) && found_reg;
    assign stat.out_free   = out_free;

    // RAM writes: shift moves entry i+1 to i, add appends at the fill count
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (cmd.shift && chk_valid_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && add_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {b_reg, a_reg};
        end
    end

    // Scan pipe, search result and pending neighbor
    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_nb_next    = hold_nb_reg;
        count_next      = count_reg;
        if (cmd.load)
        begin
            rd_idx_next     = '0;
            chk_valid_next  = 1'b0;
            found_next      = 1'b0;
            hold_valid_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            rd_idx_next    = CNT_W'(found_idx_reg) + CNT_W'(1);
            chk_valid_next = 1'b0;
        end
        else if ((cmd.scan || cmd.shift) && !stall)
        begin
            chk_valid_next = issue_go;
            chk_idx_next   = rd_idx_reg[IDX_W-1:0];
            if (issue_go)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (cmd.scan && edge_hit && !found_reg && !is_list)
            begin
                found_next     = 1'b1;
                found_idx_next = chk_idx_reg;
            end
            if (list_hit && cmd.scan)
            begin
                hold_valid_next = 1'b1;
                hold_nb_next    = list_nb;
            end
        end
        if (cmd.finish)
        begin
            if (add_ok)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (stat.need_shift)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Output register: intermediate neighbors and the final result
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_nb_next    = out_nb_reg;
        out_adj_next   = out_adj_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        if (push_mid)
        begin
            out_valid_next = 1'b1;
            out_nb_next    = NODE_FIELD_W'(hold_nb_reg);
            out_adj_next   = 1'b0;
            out_st_next    = ST_OK;
            out_last_next  = 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_nb_next    = '0;
            out_adj_next   = 1'b0;
            out_st_next    = ST_OK;
            out_last_next  = 1'b1;
            case (action_reg)
                ACT_ADD:
                begin
                    if (found_reg)
                    begin
                        out_st_next = ST_PRESENT;
                    end
                    else if (full)
                    begin
                        out_st_next = ST_FULL;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!found_reg)
                    begin
                        out_st_next = ST_NOTFOUND;
                    end
                end
                ACT_TEST:
                begin
                    out_adj_next = found_reg;
                end
                ACT_LIST:
                begin
                    if (hold_valid_reg)
                    begin
                        out_nb_next = NODE_FIELD_W'(hold_nb_reg);
                    end
                    else
                    begin
                        out_st_next = ST_NONE;
                    end
                end
                default:
                begin
                    out_st_next = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            a_reg      <= NODE_BITS'(in_node_a);
            b_reg      <= NODE_BITS'(in_node_b);
        end
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        found_idx_reg <= found_idx_next;
        hold_nb_reg   <= hold_nb_next;
        out_nb_reg    <= out_nb_next;
        out_adj_reg   <= out_adj_next;
        out_st_reg    <= out_st_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_neighbor = out_nb_reg;
    assign out_adjacent = out_adj_reg;
    assign out_status   = out_st_reg;
    assign out_last     = out_last_reg;

    // Fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_EDGES))
        else $error("edge count above table size");

    // Only stored entries are ever compared or moved
    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (CNT_W'(chk_idx_reg) < count_reg))
        else $error("read pipe beyond fill count");

    // Fill count moves only when a transaction is finished
    a_count_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(cmd.finish))
        else $error("edge count changed outside finish");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(push_mid || cmd.finish))
        else $error("output register overwritten");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for undirected_edge_table: directed and random add, remove,
// test and list transactions checked against an in-bench prediction of the edge table.
// Depends on uet_pkg and the undirected_edge_table RTL.
module testbench;
    import uet_pkg::*;

    // One expected result transaction
    typedef struct packed {
        logic [15:0]     neighbor;
        logic            adjacent;
        logic [ST_W-1:0] status;
        logic            last;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] node_a, [31:16] node_b
    logic [1:0]  s_tuser = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [15:0] neighbor, [16] adjacent, [19:17] status
    logic        m_tlast;

    // Predicted edge table
    logic [15:0] table_node_a [UET_MAX_EDGES];
    logic [15:0] table_node_b [UET_MAX_EDGES];
    int          table_count = 0;

    table_result_t expected_results [$];
    int          err_count = 0;

    // Traffic shaping
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    logic [15:0] node_pool [8];

    undirected_edge_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Index of the first stored edge joining a and b in either order, or -1
    function automatic int locate_edge(input logic [15:0] a, input logic [15:0] b);
        for (int i = 0; i < table_count; i++)
        begin
            if ((table_node_a[i] == a && table_node_b[i] == b) ||
                (table_node_a[i] == b && table_node_b[i] == a))
                return i;
        end
        return -1;
    endfunction

    function automatic table_result_t make_result(input logic [15:0] nb, input logic adj,
                                                  input logic [ST_W-1:0] st, input logic lst);
        table_result_t r;
        r.neighbor = nb;
        r.adjacent = adj;
        r.status   = st;
        r.last     = lst;
        return r;
    endfunction

    // Update the predicted table for one accepted transaction, queue its results
    task automatic predict_table_op(input logic [ACT_W-1:0] act, input logic [15:0] a,
                                    input logic [15:0] b);
        int idx;
        int hits;
        table_result_t r;
        idx  = locate_edge(a, b);
        hits = 0;
        case (act)
            ACT_ADD:
            begin
                if (idx >= 0)
                    expected_results.push_back(make_result('0, 1'b0, ST_PRESENT, 1'b1));
                else if (table_count >= UET_MAX_EDGES)
                    expected_results.push_back(make_result('0, 1'b0, ST_FULL, 1'b1));
                else
                begin
                    table_node_a[table_count] = a;
                    table_node_b[table_count] = b;
                    table_count++;
                    expected_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
                end
            end
            ACT_REMOVE:
            begin
                if (idx < 0)
                    expected_results.push_back(make_result('0, 1'b0, ST_NOTFOUND, 1'b1));
                else
                begin
                    for (int i = idx; i + 1 < table_count; i++)
                    begin
                        table_node_a[i] = table_node_a[i + 1];
                        table_node_b[i] = table_node_b[i + 1];
                    end
                    table_count--;
                    expected_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
                end
            end
            ACT_TEST:
                expected_results.push_back(make_result('0, idx >= 0, ST_OK, 1'b1));
            default:
            begin
                // neighbors in table order; a self loop matches the first test only
                for (int i = 0; i < table_count; i++)
                begin
                    if (table_node_a[i] == a)
                    begin
                        expected_results.push_back(make_result(table_node_b[i], 1'b0, ST_OK, 1'b0));
                        hits++;
                    end
                    else if (table_node_b[i] == a)
                    begin
                        expected_results.push_back(make_result(table_node_a[i], 1'b0, ST_OK, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                    expected_results.push_back(make_result('0, 1'b0, ST_NONE, 1'b1));
                else
                begin
                    r = expected_results.pop_back();
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // Send one transaction; s_tvalid stays high on return so a back-to-back item
    // keeps it up; the next send drives it again, or the drain task lowers it
    task automatic send_table_op(input logic [ACT_W-1:0] act, input logic [15:0] a,
                                 input logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_table_op(act, a, b);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_node();
        if ($urandom_range(99) < 65)
            return node_pool[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                          m_tdata, m_tlast));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.neighbor)
                    report_mismatch($sformatf("neighbor %h, want %h", m_tdata[15:0],
                                              want.neighbor));
                if (m_tdata[16] !== want.adjacent)
                    report_mismatch($sformatf("adjacent %b, want %b", m_tdata[16],
                                              want.adjacent));
                if (m_tdata[19:17] !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_tdata[19:17],
                                              want.status));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    end

    // List, test and remove on an empty table
    task automatic test_empty_table();
        send_table_op(ACT_LIST, 16'h0000, 16'hFFFF);
        send_table_op(ACT_TEST, 16'h0000, 16'hFFFF);
        send_table_op(ACT_REMOVE, 16'hFFFF, 16'h0000);
    endtask

    // Field extremes, reversed pairs, self loop and removal shifting
    task automatic test_edge_cases();
        send_table_op(ACT_ADD, 16'h0000, 16'hFFFF);
        send_table_op(ACT_ADD, 16'hFFFF, 16'h0000);   // same edge reversed
        send_table_op(ACT_ADD, 16'hFFFF, 16'hFFFF);   // self loop
        send_table_op(ACT_ADD, 16'h5555, 16'hAAAA);
        send_table_op(ACT_LIST, 16'hFFFF, 16'h1234);
        send_table_op(ACT_LIST, 16'h0000, 16'h0000);
        send_table_op(ACT_LIST, 16'hAAAA, 16'h5555);
        send_table_op(ACT_TEST, 16'hFFFF, 16'h0000);
        send_table_op(ACT_TEST, 16'h0000, 16'h0000);
        send_table_op(ACT_TEST, 16'hFFFF, 16'hFFFF);
        send_table_op(ACT_REMOVE, 16'hFFFF, 16'h0000); // head entry, reversed
        send_table_op(ACT_LIST, 16'hFFFF, 16'hFFFF);
        send_table_op(ACT_REMOVE, 16'h0000, 16'hFFFF); // already gone
        send_table_op(ACT_REMOVE, 16'hFFFF, 16'hFFFF);
        send_table_op(ACT_REMOVE, 16'hAAAA, 16'h5555);
        send_table_op(ACT_LIST, 16'h5555, 16'h0000);
        send_table_op(ACT_TEST, 16'h5555, 16'hAAAA);
    endtask

    // Random mix biased toward nodes that already carry edges
    task automatic test_random_traffic(input int n_items);
        int sel;
        int idx;
        logic [15:0] a;
        logic [15:0] b;
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(99);
            a   = pick_node();
            b   = pick_node();
            if (table_count > 0 && sel >= 40 && $urandom_range(99) < 60)
            begin
                idx = $urandom_range(table_count - 1);
                a   = table_node_a[idx];
                b   = table_node_b[idx];
                if ($urandom_range(1))
                    {a, b} = {b, a};
            end
            if (sel < 40)
                send_table_op(ACT_ADD, a, b);
            else if (sel < 60)
                send_table_op(ACT_REMOVE, a, b);
            else if (sel < 75)
                send_table_op(ACT_TEST, a, b);
            else
                send_table_op(ACT_LIST, a, 16'($urandom));
        end
    endtask

    // Remove a random stored edge in random orientation
    task automatic remove_random_entry();
        int idx;
        idx = $urandom_range(table_count - 1);
        if ($urandom_range(1))
            send_table_op(ACT_REMOVE, table_node_b[idx], table_node_a[idx]);
        else
            send_table_op(ACT_REMOVE, table_node_a[idx], table_node_b[idx]);
    endtask

    // Fill to capacity around one hub node, overflow it, stall the output, drain it
    task automatic test_full_table();
        logic [15:0] hub;
        logic [15:0] x;
        int idx;
        while (table_count > 0)
            remove_random_entry();
        hub = pick_node();
        while (table_count < UET_MAX_EDGES)
        begin
            x = 16'($urandom);
            if (locate_edge(hub, x) < 0)
            begin
                if ($urandom_range(1))
                    send_table_op(ACT_ADD, hub, x);
                else
                    send_table_op(ACT_ADD, x, hub);
            end
        end

        // long output stall while the largest lists queue up behind it
        hold_request = 400;
        send_table_op(ACT_LIST, hub, 16'($urandom));
        send_table_op(ACT_LIST, hub, 16'($urandom));
        send_table_op(ACT_ADD, table_node_b[5], table_node_a[5]);  // present beats full
        do
            x = 16'($urandom);
        while (locate_edge(hub, x) >= 0);
        send_table_op(ACT_ADD, hub, x);                              // full
        send_table_op(ACT_TEST, table_node_a[UET_MAX_EDGES - 1], table_node_b[UET_MAX_EDGES - 1]);

        // removals at the middle, the head and the tail
        send_table_op(ACT_REMOVE, table_node_a[UET_MAX_EDGES / 2], table_node_b[UET_MAX_EDGES / 2]);
        send_table_op(ACT_REMOVE, table_node_b[0], table_node_a[0]);
        idx = table_count - 1;
        send_table_op(ACT_REMOVE, table_node_a[idx], table_node_b[idx]);
        send_table_op(ACT_ADD, x, hub);
        send_table_op(ACT_LIST, hub, 16'h0000);

        // drain in random order with a periodic listing
        while (table_count > 0)
        begin
            remove_random_entry();
            if (table_count % 8 == 0)
                send_table_op(ACT_LIST, hub, 16'($urandom));
        end
    endtask

    initial
    begin
        node_pool[0] = 16'h0000;
        node_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            node_pool[i] = 16'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 28;
        recv_idle_pct = 72;
        test_empty_table();
        test_edge_cases();
        test_random_traffic(70);
        wait_results_done();

        // receiver idles lightly, sender heavily
        send_idle_pct = 72;
        recv_idle_pct = 28;
        test_full_table();
        wait_results_done();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(70);
        wait_results_done();

        repeat (150) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
